// ----- rtl/bbdq_pkg.sv -----
// Shared types and constants for the byte-budget descriptor queue.
// No dependencies; imported by bbdq_ctrl, bbdq_dp and the top level.
package bbdq_pkg;

  localparam int TAG_W   = 16;
  localparam int LEN_W   = 27;
  localparam int BIN_W   = 7;
  localparam int DROP_W  = 32;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  localparam logic [LEN_W-1:0] MAX_BYTES_RST = 27'd67108864;

  // Register index of the byte budget
  localparam logic REG_MAX_BYTES = 1'b0;

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_PEEK  = 2'd1,
    OP_DROP  = 2'd2,
    OP_COUNT = 2'd3
  } op_t;

  // Controller -> datapath
  typedef struct packed {
    logic latch;          // capture the input transfer
    logic enq_commit;     // store descriptor, emit accepted result
    logic enq_refuse;     // count refusal, emit refused result
    logic peek_start;     // read head descriptor, load batch counter
    logic peek_emit;      // emit peeked descriptor, read next
    logic drop_start;     // read head descriptor, load batch counter
    logic drop_step;      // retire head descriptor
    logic emit_simple;    // emit plain status result
    logic emit_drop_end;  // emit drop result with recovery check
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    op_t  op;
    logic enq_refuse;
    logic n_zero;
    logic batch_zero;
    logic rem_last;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/byte_budget_descriptor_queue_core.sv -----
// Top level of the byte-budget descriptor queue: APB register decode,
// controller and datapath. Depends on bbdq_pkg, bbdq_ctrl and bbdq_dp.
//
// Input channel (in_valid/in_stall): one transfer per request: enqueue,
// peek batch, drop-head batch or count query.
// Output channel (out_valid/out_stall): one transfer per result. Enqueue,
// drop-head and count give one result; a peek gives one per peeked
// descriptor (one empty result for an empty queue or zero batch); last
// marks a request's last result. APB: budget at address 0, pready high.
// Timing: one request at a time, taken in the idle state. Enqueue,
//   count, empty peek, zero-batch drop: the idle state latches the
//   request and the decide state does the budget add/compare and the
//   ring write. Peek: decide, then one emit step per descriptor; drop:
//   decide, one retire step per descriptor, then the recovery check. The
//   single ring read port reads one descriptor per cycle unless stalled.
// Reset (rst, synchronous) empties the queue, clears the drop counter and
// full flag and reloads the byte budget to 64 MiB; ring contents stay.
// While out_stall holds a result in the output register, the next request
// may be taken but waits before producing its result.
module byte_budget_descriptor_queue_core #(
  parameter int QUEUE_DEPTH = 4096,
  parameter int MAX_BATCH   = 64,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bbdq_pkg::APB_AW-1:0]   paddr,
  input  logic [bbdq_pkg::APB_DW-1:0]   pwdata,
  output logic [bbdq_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    op,
  input  logic [bbdq_pkg::TAG_W-1:0]    payload_tag,
  input  logic [bbdq_pkg::LEN_W-1:0]    payload_size,
  input  logic [bbdq_pkg::BIN_W-1:0]    batch_count,
  input  logic                          shutting_down,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          accepted,
  output logic                          has_entry,
  output logic [bbdq_pkg::TAG_W-1:0]    entry_tag,
  output logic [bbdq_pkg::LEN_W-1:0]    entry_length,
  output logic                          last,
  output logic [CW-1:0]                 queued_count,
  output logic [bbdq_pkg::LEN_W-1:0]    occupied_bytes,
  output logic [bbdq_pkg::DROP_W-1:0]   dropped_total,
  output logic                          recovered,
  output logic [bbdq_pkg::DROP_W-1:0]   dropped_at_recovery
);
  import bbdq_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic             cfg_we;
  logic             reg_sel;
  logic [LEN_W-1:0] max_bytes;

  // One word register; paddr[2] is the register index.
  assign reg_sel = (paddr[2] == REG_MAX_BYTES);
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? APB_DW'(max_bytes) : '0;

  bbdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bbdq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_BATCH   (MAX_BATCH)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_wdata           (pwdata[LEN_W-1:0]),
    .max_bytes           (max_bytes),
    .op                  (op),
    .payload_tag         (payload_tag),
    .payload_size        (payload_size),
    .batch_count         (batch_count),
    .shutting_down       (shutting_down),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .accepted            (accepted),
    .has_entry           (has_entry),
    .entry_tag           (entry_tag),
    .entry_length        (entry_length),
    .last                (last),
    .queued_count        (queued_count),
    .occupied_bytes      (occupied_bytes),
    .dropped_total       (dropped_total),
    .recovered           (recovered),
    .dropped_at_recovery (dropped_at_recovery)
  );

`ifndef SYNTHESIS
  // occupancy never passes the ring depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (queued_count <= CW'(QUEUE_DEPTH)))
    else $error("queued_count above depth");

  // recovery clears the drop counter and closes the request
  a_recover_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && recovered) |-> (dropped_total == '0 && last && !has_entry))
    else $error("recovery result inconsistent");

  // a peeked descriptor is never also an enqueue acknowledge
  a_kind_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(has_entry && accepted))
    else $error("result both peek and accept");

  // no request is taken while another is in flight
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while busy");
`endif

endmodule

// ----- rtl/bbdq_ctrl.sv -----
// Sequencing state machine for the byte-budget descriptor queue.
// Depends on bbdq_pkg (cmd_t, sts_t, op_t).
module bbdq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  bbdq_pkg::sts_t sts,
  output bbdq_pkg::cmd_t cmd
);
  import bbdq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECIDE = 5'b00010,
    S_PEEK   = 5'b00100,
    S_DROP   = 5'b01000,
    S_DEND   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (sts.op)
          OP_ENQ: begin
            if (sts.out_free) begin
              cmd.enq_refuse = sts.enq_refuse;
              cmd.enq_commit = !sts.enq_refuse;
              state_next     = S_IDLE;
            end
          end
          OP_PEEK: begin
            if (sts.n_zero) begin
              if (sts.out_free) begin
                cmd.emit_simple = 1'b1;
                state_next      = S_IDLE;
              end
            end else begin
              cmd.peek_start = 1'b1;
              state_next     = S_PEEK;
            end
          end
          OP_DROP: begin
            if (sts.batch_zero) begin
              if (sts.out_free) begin
                cmd.emit_simple = 1'b1;
                state_next      = S_IDLE;
              end
            end else if (sts.n_zero) begin
              state_next = S_DEND;
            end else begin
              cmd.drop_start = 1'b1;
              state_next     = S_DROP;
            end
          end
          OP_COUNT: begin
            if (sts.out_free) begin
              cmd.emit_simple = 1'b1;
              state_next      = S_IDLE;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_PEEK: begin
        if (sts.out_free) begin
          cmd.peek_emit = 1'b1;
          if (sts.rem_last) state_next = S_IDLE;
        end
      end
      S_DROP: begin
        cmd.drop_step = 1'b1;
        if (sts.rem_last) state_next = S_DEND;
      end
      S_DEND: begin
        if (sts.out_free) begin
          cmd.emit_drop_end = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/bbdq_dp.sv -----
// Datapath of the byte-budget descriptor queue: descriptor ring memory,
// occupancy and budget registers, drop counter and output register.
// Depends on bbdq_pkg; driven by bbdq_ctrl commands.
module bbdq_dp #(
  parameter int QUEUE_DEPTH = 4096,
  parameter int MAX_BATCH   = 64,
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bbdq_pkg::cmd_t               cmd,
  output bbdq_pkg::sts_t               sts,
  input  logic                         cfg_we,
  input  logic [bbdq_pkg::LEN_W-1:0]   cfg_wdata,
  output logic [bbdq_pkg::LEN_W-1:0]   max_bytes,
  input  logic [1:0]                   op,
  input  logic [bbdq_pkg::TAG_W-1:0]   payload_tag,
  input  logic [bbdq_pkg::LEN_W-1:0]   payload_size,
  input  logic [bbdq_pkg::BIN_W-1:0]   batch_count,
  input  logic                         shutting_down,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic                         accepted,
  output logic                         has_entry,
  output logic [bbdq_pkg::TAG_W-1:0]   entry_tag,
  output logic [bbdq_pkg::LEN_W-1:0]   entry_length,
  output logic                         last,
  output logic [CW-1:0]                queued_count,
  output logic [bbdq_pkg::LEN_W-1:0]   occupied_bytes,
  output logic [bbdq_pkg::DROP_W-1:0]  dropped_total,
  output logic                         recovered,
  output logic [bbdq_pkg::DROP_W-1:0]  dropped_at_recovery
);
  import bbdq_pkg::*;

  localparam int BW   = $clog2(MAX_BATCH + 1);
  localparam int MW   = (CW > BW) ? CW : BW;
  localparam int DW   = TAG_W + LEN_W;
  localparam logic [CW-1:0] HALF = CW'(QUEUE_DEPTH / 2);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [DW-1:0]     mem [QUEUE_DEPTH];
  logic [DW-1:0]     rd_data;
  logic [AW-1:0]     rd_addr;
  logic              rd_en;

  op_t               op_q;
  logic [TAG_W-1:0]  tag_q;
  logic [LEN_W-1:0]  len_q;
  logic [BW-1:0]     batch_q;
  logic              stop_q;

  logic [AW-1:0]     head, head_next;
  logic [AW-1:0]     rd_ptr;
  logic [CW-1:0]     count_q, count_next;
  logic [LEN_W-1:0]  bytes_q, bytes_next;
  logic [DROP_W-1:0] refused_q, refused_next;
  logic              full_q, full_next;
  logic [BW-1:0]     rem;

  logic [LEN_W:0]    sum_bytes;
  logic [AW:0]       slot_sum;
  logic [AW-1:0]     slot;
  logic [MW-1:0]     n_wide;
  logic [BW-1:0]     n_b;
  logic [BW-1:0]     batch_clamp;
  logic [LEN_W-1:0]  rd_len;
  logic [TAG_W-1:0]  rd_tag;
  logic              rec;
  logic [DROP_W-1:0] rec_val;
  logic              emit;

  assign rd_tag = rd_data[DW-1:LEN_W];
  assign rd_len = rd_data[LEN_W-1:0];

  assign batch_clamp = (batch_count > BIN_W'(MAX_BATCH)) ? BW'(MAX_BATCH)
                                                         : batch_count[BW-1:0];

  assign sum_bytes = {1'b0, bytes_q} + {1'b0, len_q};
  assign slot_sum  = {1'b0, head} + {1'b0, count_q[AW-1:0]};
  assign slot      = (slot_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                     AW'(slot_sum - (AW+1)'(QUEUE_DEPTH)) : slot_sum[AW-1:0];

  assign n_wide = (MW'(count_q) < MW'(batch_q)) ? MW'(count_q) : MW'(batch_q);
  assign n_b    = n_wide[BW-1:0];

  assign sts.op         = op_q;
  assign sts.enq_refuse = stop_q || (count_q >= CW'(QUEUE_DEPTH)) ||
                          (sum_bytes > {1'b0, max_bytes});
  assign sts.n_zero     = (n_b == '0);
  assign sts.batch_zero = (batch_q == '0);
  assign sts.rem_last   = (rem == BW'(1));
  assign sts.out_free   = !out_valid || !out_stall;

  assign emit = cmd.enq_commit | cmd.enq_refuse | cmd.peek_emit |
                cmd.emit_simple | cmd.emit_drop_end;

  // Read port: head on batch start, then one entry ahead per step.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head;
    if (cmd.peek_start || cmd.drop_start) begin
      rd_en   = 1'b1;
      rd_addr = head;
    end else if (cmd.peek_emit) begin
      rd_en   = !sts.rem_last;
      rd_addr = rd_ptr;
    end else if (cmd.drop_step) begin
      rd_en   = !sts.rem_last;
      rd_addr = ptr_inc(head);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enq_commit) begin
      mem[slot] <= {tag_q, len_q};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    head_next    = head;
    count_next   = count_q;
    bytes_next   = bytes_q;
    refused_next = refused_q;
    full_next    = full_q;
    rec          = 1'b0;
    rec_val      = '0;
    if (cmd.enq_commit) begin
      count_next = count_q + 1'b1;
      bytes_next = sum_bytes[LEN_W-1:0];
    end
    if (cmd.enq_refuse) begin
      if (refused_q != '1) refused_next = refused_q + 1'b1;
      full_next = 1'b1;
    end
    if (cmd.drop_step) begin
      head_next  = ptr_inc(head);
      count_next = count_q - 1'b1;
      bytes_next = (rd_len <= bytes_q) ? bytes_q - rd_len : '0;
    end
    if (cmd.emit_drop_end && full_q && (count_q < HALF)) begin
      rec          = 1'b1;
      rec_val      = refused_q;
      refused_next = '0;
      full_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count_q   <= '0;
      bytes_q   <= '0;
      refused_q <= '0;
      full_q    <= 1'b0;
      max_bytes <= MAX_BYTES_RST;
      out_valid <= 1'b0;
    end else begin
      head      <= head_next;
      count_q   <= count_next;
      bytes_q   <= bytes_next;
      refused_q <= refused_next;
      full_q    <= full_next;
      if (cfg_we) max_bytes <= cfg_wdata;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Captured input, batch counter, peek pointer and result payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q    <= op_t'(op);
      tag_q   <= payload_tag;
      len_q   <= payload_size;
      batch_q <= batch_clamp;
      stop_q  <= shutting_down;
    end
    if (cmd.peek_start || cmd.drop_start) begin
      rem    <= n_b;
      rd_ptr <= ptr_inc(head);
    end else if (cmd.peek_emit || cmd.drop_step) begin
      rem    <= rem - 1'b1;
      rd_ptr <= ptr_inc(rd_ptr);
    end
    if (emit) begin
      accepted            <= cmd.enq_commit;
      has_entry           <= cmd.peek_emit;
      entry_tag           <= cmd.peek_emit ? rd_tag : '0;
      entry_length        <= cmd.peek_emit ? rd_len : '0;
      last                <= cmd.peek_emit ? sts.rem_last : 1'b1;
      queued_count        <= count_next;
      occupied_bytes      <= bytes_next;
      dropped_total       <= refused_next;
      recovered           <= rec;
      dropped_at_recovery <= rec_val;
    end
  end

endmodule
